// File: rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int MAX_BYTES_DEF = 16;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [7:0] HALF_BIT_RESET   = 8'd2;
    localparam logic [7:0] START_STOP_RESET = 8'd4;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_HALF_BIT   = 2'd0,
        CFG_START_STOP = 2'd1,
        CFG_ACK_TIMEOUT = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_ST_HIGH   = 5'd1,
        PH_ST_LOW    = 5'd2,
        PH_TX_LOW    = 5'd3,
        PH_TX_HIGH   = 5'd4,
        PH_ACK_LOW   = 5'd5,
        PH_ACK_HIGH  = 5'd6,
        PH_RX_LOW    = 5'd7,
        PH_RX_HIGH   = 5'd8,
        PH_MACK_LOW  = 5'd9,
        PH_MACK_HIGH = 5'd10,
        PH_SP_LOW    = 5'd11,
        PH_SP_HIGH   = 5'd12,
        PH_SP_END    = 5'd13
    } phase_t;

    typedef enum logic [1:0] {
        STG_ADDR_W = 2'd0,
        STG_REG    = 2'd1,
        STG_ADDR_R = 2'd2,
        STG_DATA   = 2'd3
    } stage_t;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  device_addr;
        logic [7:0]  reg_addr;
        logic        is_read;
        logic [4:0]  byte_count;
        logic [7:0]  write_byte;
        logic        sda_in;
    } item_t;

    typedef struct packed {
        logic        busy_res;
        logic        status;
        logic        done_res;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        sda_drive;
        logic        sda_level;
        logic        scl_level;
    } result_t;

endpackage

// File: rtl/i2cm_wbuf.sv
`timescale 1ns / 1ps

module i2cm_wbuf #(
    parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF,
    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [7:0]       wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [7:0]       rdata
);

    logic [7:0] buf_reg [MAX_BYTES];
    logic [7:0] rdata_reg;

    // The read index moves on a load, a send, a start or the end of a stop, and a
    // whole byte goes out between sends, so the registered read is always current.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            buf_reg[waddr] <= wdata;
        end
        rdata_reg <= buf_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/i2cm_ctrl.sv
`timescale 1ns / 1ps

module i2cm_ctrl #(
    parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF,
    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               step_en,
    input  i2cm_pkg::item_t    item,
    output i2cm_pkg::result_t  result,
    output logic               buf_we,
    output logic [IDX_W-1:0]   buf_addr,
    input  logic [7:0]         buf_rdata
);

    localparam logic [IDX_W:0] MAX_IDX = (IDX_W+1)'(MAX_BYTES);
    localparam logic [7:0]     MAX_CNT = 8'(MAX_BYTES);

    logic [7:0] half_bit_ticks_reg, start_stop_ticks_reg, ack_timeout_reg;

    i2cm_pkg::phase_t phase_reg, phase_next;
    i2cm_pkg::stage_t stage_reg, stage_next;
    logic [7:0]       tick_count_reg, tick_count_next;
    logic [2:0]       bit_index_reg, bit_index_next;
    logic [7:0]       shift_byte_reg, shift_byte_next;
    logic [4:0]       bytes_left_reg, bytes_left_next;
    logic [IDX_W-1:0] buffer_index_reg, buffer_index_next;
    logic [15:0]      saved_request_reg, saved_request_next;
    logic [7:0]       poll_count_reg, poll_count_next;
    logic             err_flag_reg, err_flag_next;

    logic [7:0]       dur_h, dur_s;
    logic [8:0]       tick_inc;
    logic             adv_h, adv_s;
    logic [IDX_W-1:0] idx_cur, idx_inc;
    logic [7:0]       rx_byte;
    logic [7:0]       rdata_c;
    logic             rvalid_c, done_c, status_c;

    assign dur_h    = (half_bit_ticks_reg == 8'd0) ? 8'd1 : half_bit_ticks_reg;
    assign dur_s    = (start_stop_ticks_reg == 8'd0) ? 8'd1 : start_stop_ticks_reg;
    assign tick_inc = {1'b0, tick_count_reg} + 9'd1;
    assign adv_h    = tick_inc >= {1'b0, dur_h};
    assign adv_s    = tick_inc >= {1'b0, dur_s};

    assign idx_cur  = ({1'b0, buffer_index_reg} < MAX_IDX) ? buffer_index_reg : '0;
    assign idx_inc  = (({1'b0, idx_cur} + 1'b1) >= MAX_IDX) ? '0
                      : IDX_W'({1'b0, idx_cur} + 1'b1);
    assign buf_addr = idx_cur;
    assign buf_we   = step_en && item.mode == i2cm_pkg::MODE_LOAD
                      && phase_reg == i2cm_pkg::PH_IDLE;
    assign rx_byte  = {shift_byte_reg[6:0], item.sda_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_ticks_reg   <= i2cm_pkg::HALF_BIT_RESET;
            start_stop_ticks_reg <= i2cm_pkg::START_STOP_RESET;
            ack_timeout_reg      <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (i2cm_pkg::cfg_index_t'(cfg_index))
                i2cm_pkg::CFG_HALF_BIT:    half_bit_ticks_reg   <= cfg_data;
                i2cm_pkg::CFG_START_STOP:  start_stop_ticks_reg <= cfg_data;
                i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= i2cm_pkg::PH_IDLE;
            stage_reg         <= i2cm_pkg::STG_ADDR_W;
            tick_count_reg    <= '0;
            bit_index_reg     <= '0;
            shift_byte_reg    <= '0;
            bytes_left_reg    <= '0;
            buffer_index_reg  <= '0;
            saved_request_reg <= '0;
            poll_count_reg    <= '0;
            err_flag_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            stage_reg         <= stage_next;
            tick_count_reg    <= tick_count_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            bytes_left_reg    <= bytes_left_next;
            buffer_index_reg  <= buffer_index_next;
            saved_request_reg <= saved_request_next;
            poll_count_reg    <= poll_count_next;
            err_flag_reg      <= err_flag_next;
        end
    end

    // Next state of the bus sequencer for one word.
    always_comb
    begin
        logic ack_ok;
        logic ack_fail;
        logic send_next;
        ack_ok             = item.sda_in == 1'b0;
        ack_fail           = !ack_ok && (poll_count_reg >= ack_timeout_reg);
        send_next          = 1'b0;
        phase_next         = phase_reg;
        stage_next         = stage_reg;
        tick_count_next    = tick_count_reg;
        bit_index_next     = bit_index_reg;
        shift_byte_next    = shift_byte_reg;
        bytes_left_next    = bytes_left_reg;
        buffer_index_next  = buffer_index_reg;
        saved_request_next = saved_request_reg;
        poll_count_next    = poll_count_reg;
        err_flag_next      = err_flag_reg;
        rdata_c            = 8'd0;
        rvalid_c           = 1'b0;
        done_c             = 1'b0;
        status_c           = 1'b0;

        case (item.mode)
            i2cm_pkg::MODE_START:
            begin
                if (phase_reg == i2cm_pkg::PH_IDLE)
                begin
                    saved_request_next = {item.device_addr, item.is_read, item.reg_addr};
                    bytes_left_next    = ({3'b000, item.byte_count} > MAX_CNT)
                                         ? MAX_CNT[4:0] : item.byte_count;
                    buffer_index_next  = '0;
                    stage_next         = i2cm_pkg::STG_ADDR_W;
                    err_flag_next      = 1'b0;
                    tick_count_next    = '0;
                    poll_count_next    = '0;
                    phase_next         = i2cm_pkg::PH_ST_HIGH;
                end
            end
            i2cm_pkg::MODE_LOAD:
            begin
                if (phase_reg == i2cm_pkg::PH_IDLE)
                begin
                    buffer_index_next = idx_inc;
                end
            end
            i2cm_pkg::MODE_TICK:
            begin
                case (phase_reg)
                    i2cm_pkg::PH_ST_HIGH:
                    begin
                        tick_count_next = adv_s ? 8'd0 : tick_inc[7:0];
                        if (adv_s)
                        begin
                            phase_next = i2cm_pkg::PH_ST_LOW;
                        end
                    end
                    i2cm_pkg::PH_ST_LOW:
                    begin
                        tick_count_next = adv_s ? 8'd0 : tick_inc[7:0];
                        if (adv_s)
                        begin
                            shift_byte_next = {saved_request_reg[15:9],
                                               stage_reg == i2cm_pkg::STG_ADDR_R};
                            bit_index_next  = '0;
                            phase_next      = i2cm_pkg::PH_TX_LOW;
                        end
                    end
                    i2cm_pkg::PH_TX_LOW:
                    begin
                        tick_count_next = adv_h ? 8'd0 : tick_inc[7:0];
                        if (adv_h)
                        begin
                            phase_next = i2cm_pkg::PH_TX_HIGH;
                        end
                    end
                    i2cm_pkg::PH_TX_HIGH:
                    begin
                        tick_count_next = adv_h ? 8'd0 : tick_inc[7:0];
                        if (adv_h)
                        begin
                            if (bit_index_reg == 3'd7)
                            begin
                                poll_count_next = '0;
                                phase_next      = i2cm_pkg::PH_ACK_LOW;
                            end
                            else
                            begin
                                bit_index_next  = bit_index_reg + 3'd1;
                                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                                phase_next      = i2cm_pkg::PH_TX_LOW;
                            end
                        end
                    end
                    i2cm_pkg::PH_ACK_LOW:
                    begin
                        tick_count_next = adv_h ? 8'd0 : tick_inc[7:0];
                        if (adv_h)
                        begin
                            phase_next = i2cm_pkg::PH_ACK_HIGH;
                        end
                    end
                    i2cm_pkg::PH_ACK_HIGH:
                    begin
                        if (ack_ok || ack_fail)
                        begin
                            tick_count_next = '0;
                            case (stage_reg)
                                i2cm_pkg::STG_ADDR_W:
                                begin
                                    if (!ack_ok)
                                    begin
                                        err_flag_next = 1'b1;
                                        phase_next    = i2cm_pkg::PH_SP_LOW;
                                    end
                                    else
                                    begin
                                        stage_next      = i2cm_pkg::STG_REG;
                                        shift_byte_next = saved_request_reg[7:0];
                                        bit_index_next  = '0;
                                        phase_next      = i2cm_pkg::PH_TX_LOW;
                                    end
                                end
                                i2cm_pkg::STG_REG:
                                begin
                                    if (saved_request_reg[8])
                                    begin
                                        stage_next = i2cm_pkg::STG_ADDR_R;
                                        phase_next = i2cm_pkg::PH_ST_HIGH;
                                    end
                                    else
                                    begin
                                        stage_next = i2cm_pkg::STG_DATA;
                                        send_next  = 1'b1;
                                    end
                                end
                                i2cm_pkg::STG_ADDR_R:
                                begin
                                    stage_next = i2cm_pkg::STG_DATA;
                                    if (bytes_left_reg != 5'd0)
                                    begin
                                        shift_byte_next = '0;
                                        bit_index_next  = '0;
                                        phase_next      = i2cm_pkg::PH_RX_LOW;
                                    end
                                    else
                                    begin
                                        phase_next = i2cm_pkg::PH_SP_LOW;
                                    end
                                end
                                default:
                                begin
                                    if (!ack_ok)
                                    begin
                                        err_flag_next = 1'b1;
                                        phase_next    = i2cm_pkg::PH_SP_LOW;
                                    end
                                    else
                                    begin
                                        send_next = 1'b1;
                                    end
                                end
                            endcase
                            if (send_next)
                            begin
                                if (bytes_left_reg != 5'd0)
                                begin
                                    bytes_left_next   = bytes_left_reg - 5'd1;
                                    buffer_index_next = idx_inc;
                                    shift_byte_next   = buf_rdata;
                                    bit_index_next    = '0;
                                    phase_next        = i2cm_pkg::PH_TX_LOW;
                                end
                                else
                                begin
                                    phase_next = i2cm_pkg::PH_SP_LOW;
                                end
                            end
                        end
                        else
                        begin
                            poll_count_next = poll_count_reg + 8'd1;
                        end
                    end
                    i2cm_pkg::PH_RX_LOW:
                    begin
                        tick_count_next = adv_h ? 8'd0 : tick_inc[7:0];
                        if (adv_h)
                        begin
                            phase_next = i2cm_pkg::PH_RX_HIGH;
                        end
                    end
                    i2cm_pkg::PH_RX_HIGH:
                    begin
                        if (tick_count_reg == 8'd0)
                        begin
                            shift_byte_next = rx_byte;
                            if (bit_index_reg == 3'd7)
                            begin
                                rdata_c  = rx_byte;
                                rvalid_c = 1'b1;
                            end
                        end
                        tick_count_next = adv_h ? 8'd0 : tick_inc[7:0];
                        if (adv_h)
                        begin
                            if (bit_index_reg == 3'd7)
                            begin
                                if (bytes_left_reg != 5'd0)
                                begin
                                    bytes_left_next = bytes_left_reg - 5'd1;
                                end
                                phase_next = i2cm_pkg::PH_MACK_LOW;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 3'd1;
                                phase_next     = i2cm_pkg::PH_RX_LOW;
                            end
                        end
                    end
                    i2cm_pkg::PH_MACK_LOW:
                    begin
                        tick_count_next = adv_h ? 8'd0 : tick_inc[7:0];
                        if (adv_h)
                        begin
                            phase_next = i2cm_pkg::PH_MACK_HIGH;
                        end
                    end
                    i2cm_pkg::PH_MACK_HIGH:
                    begin
                        tick_count_next = adv_h ? 8'd0 : tick_inc[7:0];
                        if (adv_h)
                        begin
                            if (bytes_left_reg != 5'd0)
                            begin
                                shift_byte_next = '0;
                                bit_index_next  = '0;
                                phase_next      = i2cm_pkg::PH_RX_LOW;
                            end
                            else
                            begin
                                phase_next = i2cm_pkg::PH_SP_LOW;
                            end
                        end
                    end
                    i2cm_pkg::PH_SP_LOW:
                    begin
                        tick_count_next = adv_s ? 8'd0 : tick_inc[7:0];
                        if (adv_s)
                        begin
                            phase_next = i2cm_pkg::PH_SP_HIGH;
                        end
                    end
                    i2cm_pkg::PH_SP_HIGH:
                    begin
                        tick_count_next = adv_s ? 8'd0 : tick_inc[7:0];
                        if (adv_s)
                        begin
                            phase_next = i2cm_pkg::PH_SP_END;
                        end
                    end
                    i2cm_pkg::PH_SP_END:
                    begin
                        done_c            = 1'b1;
                        status_c          = err_flag_reg;
                        phase_next        = i2cm_pkg::PH_IDLE;
                        tick_count_next   = '0;
                        buffer_index_next = '0;
                        bit_index_next    = '0;
                        bytes_left_next   = '0;
                        poll_count_next   = '0;
                        err_flag_next     = 1'b0;
                    end
                    default:
                    begin
                        phase_next = i2cm_pkg::PH_IDLE;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Bus levels follow the phase that the word runs in.
    always_comb
    begin
        result.scl_level  = 1'b1;
        result.sda_level  = 1'b1;
        result.sda_drive  = 1'b1;
        case (phase_reg)
            i2cm_pkg::PH_ST_LOW:
            begin
                result.sda_level = 1'b0;
            end
            i2cm_pkg::PH_TX_LOW:
            begin
                result.scl_level = 1'b0;
                result.sda_level = shift_byte_reg[7];
            end
            i2cm_pkg::PH_TX_HIGH:
            begin
                result.sda_level = shift_byte_reg[7];
            end
            i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_RX_LOW:
            begin
                result.scl_level = 1'b0;
                result.sda_drive = 1'b0;
            end
            i2cm_pkg::PH_ACK_HIGH, i2cm_pkg::PH_RX_HIGH:
            begin
                result.sda_drive = 1'b0;
            end
            i2cm_pkg::PH_MACK_LOW:
            begin
                result.scl_level = 1'b0;
                result.sda_level = bytes_left_reg == 5'd0;
            end
            i2cm_pkg::PH_MACK_HIGH:
            begin
                result.sda_level = bytes_left_reg == 5'd0;
            end
            i2cm_pkg::PH_SP_LOW:
            begin
                result.scl_level = 1'b0;
                result.sda_level = 1'b0;
            end
            i2cm_pkg::PH_SP_HIGH:
            begin
                result.sda_level = 1'b0;
            end
            default: ;
        endcase
        result.read_data  = rdata_c;
        result.read_valid = rvalid_c;
        result.done_res   = done_c;
        result.status     = status_c;
        result.busy_res   = phase_next != i2cm_pkg::PH_IDLE;
    end

endmodule

// File: rtl/i2c_master_register_transfer_unit.sv
`timescale 1ns / 1ps

// I2C master for register access, stepped one word at a time.
// Input words arrive on the s_axis channel; tuser carries the mode (tick,
// start command, load of one write byte, or none) and tdata carries the fields.
// Write bytes are loaded first, then a start command launches the transfer,
// and each tick word after that advances the bus sequence by one step and
// carries the sampled SDA level.
// Every input word yields exactly one output word on m_axis with the SCL and
// SDA levels for that tick, a received byte when one completes, and the done
// pulse with status at the end of the stop condition.
// Each input word passes through one input register and one result register
// on its way to the output word. One word is accepted every cycle while
// the receiver keeps up.
// When the receiver stalls, the result register holds its word and the input
// register takes one more word only if it is empty before s_axis_tready drops.
// Reset puts the sequencer in idle, restores the default timing registers,
// and empties both pipeline registers. The write buffer holds no valid data
// until it is loaded.
// Timing registers are written through cfg_we, cfg_index and cfg_data.
module i2c_master_register_transfer_unit #(
    parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF,
    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // device_addr[6:0], reg_addr[14:7], is_read[15], byte_count[20:16],
    // write_byte[28:21], sda_in[29], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_level[0], sda_level[1], sda_drive[2], read_data[10:3],
    // read_valid[11], done_res[12], status[13], busy_res[14], zero[15]
    output logic [15:0] m_axis_tdata
);

    logic              in_valid_reg;
    i2cm_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    i2cm_pkg::result_t out_reg;
    logic              advance;
    logic              step_en;
    i2cm_pkg::result_t result;
    logic              buf_we;
    logic [IDX_W-1:0]  buf_addr;
    logic [7:0]        buf_rdata;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.mode        <= i2cm_pkg::mode_t'(s_axis_tuser);
            in_item_reg.device_addr <= s_axis_tdata[6:0];
            in_item_reg.reg_addr    <= s_axis_tdata[14:7];
            in_item_reg.is_read     <= s_axis_tdata[15];
            in_item_reg.byte_count  <= s_axis_tdata[20:16];
            in_item_reg.write_byte  <= s_axis_tdata[28:21];
            in_item_reg.sda_in      <= s_axis_tdata[29];
        end
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    i2cm_ctrl #(
        .MAX_BYTES (MAX_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (step_en),
        .item      (in_item_reg),
        .result    (result),
        .buf_we    (buf_we),
        .buf_addr  (buf_addr),
        .buf_rdata (buf_rdata)
    );

    i2cm_wbuf #(
        .MAX_BYTES (MAX_BYTES)
    ) u_wbuf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_addr),
        .wdata (in_item_reg.write_byte),
        .raddr (buf_addr),
        .rdata (buf_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

endmodule

// File: rtl/i2cm_checker.sv
`timescale 1ns / 1ps

module i2cm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [7:0]  cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output word changed while stalled.");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[12])
        else $error("Error status without done pulse.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> !m_axis_tdata[14])
        else $error("Done pulse while still busy.");

    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("Released SDA does not read as high.");

    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[11] |-> m_axis_tdata[10:3] == 8'd0)
        else $error("Read data nonzero without read valid.");

endmodule

bind i2c_master_register_transfer_unit i2cm_checker u_i2cm_checker (.*);
